FILE: hdl/stwr_pkg.sv
// stwr_pkg: widths, operation and status codes, and the request token
// that walks the slot cell row; no dependencies
package stwr_pkg;

    localparam int SLOTS_DEF = 32;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int RC_W  = 5;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE_ONE = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic             active;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [RC_W-1:0]  receipt;
        logic             done;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] removed;
        logic [CNT_W-1:0] cnt;
    } stwr_tok_t;

endpackage

FILE: hdl/slot_table_with_receipts.sv
// slot_table_with_receipts: top level; row of stwr_cell slots, occupancy
// count and result/skid registers; uses stwr_pkg and stwr_cell
//
// Each accepted request enters the first slot cell and walks the row one cell
// per cycle, every cell acting on its own slot; after the injection register
// and every cell register, the result is registered on m_*. One request is in
// the row at a time, so a new beat is not taken until the request before it
// has left the cell row and s_ready has come back. A finished
// result may wait on m_* while the next request is taken; a second finished
// result waits in a skid register, and s_ready stays low until it moves out.
// After reset all slots are free and occupancy is zero.
module slot_table_with_receipts
    import stwr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic signed [VAL_W-1:0] s_item_value,
    input  logic [RC_W-1:0]         s_receipt,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_slot_index,
    output logic signed [VAL_W-1:0] m_removed_value,
    output logic [CNT_W-1:0]        m_match_count,
    output logic [ST_W-1:0]         m_status,
    output logic [CNT_W-1:0]        m_occupancy
);

    stwr_tok_t        chain [SLOTS+1];
    stwr_tok_t        inj_reg, inj_next;
    stwr_tok_t        tail;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    logic [ST_W-1:0]  res_status;

    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [VAL_W-1:0] m_rm_reg, m_rm_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic [ST_W-1:0]  m_st_reg, m_st_next;
    logic [CNT_W-1:0] m_occ_reg, m_occ_next;

    logic             p_valid_reg, p_valid_next;
    logic [IDX_W-1:0] p_idx_reg, p_idx_next;
    logic [VAL_W-1:0] p_rm_reg, p_rm_next;
    logic [CNT_W-1:0] p_cnt_reg, p_cnt_next;
    logic [ST_W-1:0]  p_st_reg, p_st_next;
    logic [CNT_W-1:0] p_occ_reg, p_occ_next;

    logic             in_beat;
    logic             out_beat;

    assign s_ready  = !busy_reg && !p_valid_reg;
    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid_reg && m_ready;

    always_comb begin
        inj_next         = '0;
        inj_next.active  = in_beat;
        inj_next.op      = s_operation;
        inj_next.value   = s_item_value;
        inj_next.receipt = s_receipt;
    end

    assign chain[0] = inj_reg;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        stwr_cell #(
            .CELL_ID (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (chain[i]),
            .tok_o   (chain[i+1])
        );
    end

    assign tail = chain[SLOTS];

    // status and occupancy of the request leaving the row
    always_comb begin
        res_status = ST_OK;
        occ_next   = occ_reg;
        case (tail.op)
            OP_INSERT: begin
                if (tail.done) occ_next = occ_reg + CNT_W'(1);
                else res_status = ST_FULL;
            end
            OP_REMOVE, OP_ERASE_ONE: begin
                if (tail.done) occ_next = occ_reg - CNT_W'(1);
                else res_status = ST_EMPTY;
            end
            OP_ERASE_ALL: begin
                occ_next = occ_reg - tail.cnt;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_rm_next    = m_rm_reg;
        m_cnt_next   = m_cnt_reg;
        m_st_next    = m_st_reg;
        m_occ_next   = m_occ_reg;
        p_valid_next = p_valid_reg;
        p_idx_next   = p_idx_reg;
        p_rm_next    = p_rm_reg;
        p_cnt_next   = p_cnt_reg;
        p_st_next    = p_st_reg;
        p_occ_next   = p_occ_reg;

        if (in_beat) busy_next = 1'b1;
        if (tail.active) busy_next = 1'b0;

        if (out_beat) begin
            m_valid_next = p_valid_reg;
            m_idx_next   = p_idx_reg;
            m_rm_next    = p_rm_reg;
            m_cnt_next   = p_cnt_reg;
            m_st_next    = p_st_reg;
            m_occ_next   = p_occ_reg;
            p_valid_next = 1'b0;
        end

        if (tail.active) begin
            if (!m_valid_next) begin
                m_valid_next = 1'b1;
                m_idx_next   = tail.idx;
                m_rm_next    = tail.removed;
                m_cnt_next   = tail.cnt;
                m_st_next    = res_status;
                m_occ_next   = occ_next;
            end else begin
                p_valid_next = 1'b1;
                p_idx_next   = tail.idx;
                p_rm_next    = tail.removed;
                p_cnt_next   = tail.cnt;
                p_st_next    = res_status;
                p_occ_next   = occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inj_reg.active <= 1'b0;
            busy_reg       <= 1'b0;
            occ_reg        <= '0;
            m_valid_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
        end else begin
            inj_reg.active <= inj_next.active;
            busy_reg       <= busy_next;
            if (tail.active) occ_reg <= occ_next;
            m_valid_reg    <= m_valid_next;
            p_valid_reg    <= p_valid_next;
        end
        inj_reg.op      <= inj_next.op;
        inj_reg.value   <= inj_next.value;
        inj_reg.receipt <= inj_next.receipt;
        inj_reg.done    <= inj_next.done;
        inj_reg.idx     <= inj_next.idx;
        inj_reg.removed <= inj_next.removed;
        inj_reg.cnt     <= inj_next.cnt;
        m_idx_reg       <= m_idx_next;
        m_rm_reg        <= m_rm_next;
        m_cnt_reg       <= m_cnt_next;
        m_st_reg        <= m_st_next;
        m_occ_reg       <= m_occ_next;
        p_idx_reg       <= p_idx_next;
        p_rm_reg        <= p_rm_next;
        p_cnt_reg       <= p_cnt_next;
        p_st_reg        <= p_st_next;
        p_occ_reg       <= p_occ_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_slot_index    = m_idx_reg;
    assign m_removed_value = m_rm_reg;
    assign m_match_count   = m_cnt_reg;
    assign m_status        = m_st_reg;
    assign m_occupancy     = m_occ_reg;

    a_tail_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        tail.active |-> busy_reg)
        else $error("request left the cell row while none was in flight");

    a_skid_order : assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> m_valid_reg)
        else $error("skid result held while output register empty");

    a_accept_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (busy_reg && inj_reg.active))
        else $error("accepted beat not injected into the cell row");

    a_one_in_flight : assert property (@(posedge aclk) disable iff (!aresetn)
        inj_reg.active |-> !tail.active)
        else $error("two requests in the cell row at once");

endmodule

FILE: hdl/stwr_cell.sv
// stwr_cell: one slot of the table (value and valid bit); updates the slot
// as the request token passes and hands the token on; uses stwr_pkg
module stwr_cell
    import stwr_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  stwr_tok_t tok_i,
    output stwr_tok_t tok_o
);

    logic             valid_reg, valid_next;
    logic [VAL_W-1:0] value_reg, value_next;
    stwr_tok_t        tok_reg, tok_next;
    logic             match;
    logic             mine;

    assign match = valid_reg && (value_reg == tok_i.value);
    assign mine  = (32'(tok_i.receipt) == 32'(CELL_ID));

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        tok_next   = tok_i;
        if (tok_i.active) begin
            case (tok_i.op)
                OP_INSERT: begin
                    if (!tok_i.done && !valid_reg) begin
                        valid_next    = 1'b1;
                        value_next    = tok_i.value;
                        tok_next.done = 1'b1;
                        tok_next.idx  = IDX_W'(CELL_ID);
                    end
                end
                OP_REMOVE: begin
                    if (mine && valid_reg) begin
                        valid_next       = 1'b0;
                        tok_next.done    = 1'b1;
                        tok_next.removed = value_reg;
                    end
                end
                OP_ERASE_ALL: begin
                    if (match) begin
                        valid_next   = 1'b0;
                        tok_next.cnt = tok_i.cnt + CNT_W'(1);
                    end
                end
                OP_ERASE_ONE: begin
                    if (!tok_i.done && match) begin
                        valid_next    = 1'b0;
                        tok_next.done = 1'b1;
                        tok_next.idx  = IDX_W'(CELL_ID);
                    end
                end
                OP_COUNT: begin
                    if (match) begin
                        tok_next.cnt = tok_i.cnt + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            tok_reg.active <= tok_next.active;
        end
        value_reg       <= value_next;
        tok_reg.op      <= tok_next.op;
        tok_reg.value   <= tok_next.value;
        tok_reg.receipt <= tok_next.receipt;
        tok_reg.done    <= tok_next.done;
        tok_reg.idx     <= tok_next.idx;
        tok_reg.removed <= tok_next.removed;
        tok_reg.cnt     <= tok_next.cnt;
    end

    assign tok_o = tok_reg;

endmodule

FILE: tb/sv/tb_slot_table_with_receipts.sv
`timescale 1ns / 100ps
// tb_slot_table_with_receipts: self-checking bench for the slot table; a queue-fed
// driver, a result monitor and an in-bench model of the table and its receipts
// depends on stwr_pkg and slot_table_with_receipts
module tb_slot_table_with_receipts;
    import stwr_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int QUIET_MAX  = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 2 * (SLOTS + 1);
    localparam int PHASES     = 5;
    localparam int PHASE_ITEMS = 375;
    localparam logic [OP_W-1:0] OP_TOP = '1;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [RC_W-1:0]  receipt;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] removed;
        logic [CNT_W-1:0] cnt;
        logic [ST_W-1:0]  st;
        logic [CNT_W-1:0] occ;
    } answer_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation = '0;
    logic signed [VAL_W-1:0] s_item_value = '0;
    logic [RC_W-1:0]         s_receipt = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [IDX_W-1:0]        m_slot_index;
    logic signed [VAL_W-1:0] m_removed_value;
    logic [CNT_W-1:0]        m_match_count;
    logic [ST_W-1:0]         m_status;
    logic [CNT_W-1:0]        m_occupancy;

    // table model state
    logic [VAL_W-1:0] slot_val [SLOTS];
    logic             slot_used [SLOTS];
    int               fill = 0;

    request_t requests_pending [$];
    answer_t  answers_due [$];
    logic [VAL_W-1:0] value_pool [8];

    logic in_beat = 1'b0;
    int   n_queued = 0;
    int   n_in = 0;
    int   n_out = 0;
    int   n_full = 0;
    int   n_miss = 0;
    int   peak_fill = 0;
    int   errors = 0;
    int   quiet = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    slot_table_with_receipts #(.SLOTS(SLOTS)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_item_value    (s_item_value),
        .s_receipt       (s_receipt),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_index    (m_slot_index),
        .m_removed_value (m_removed_value),
        .m_match_count   (m_match_count),
        .m_status        (m_status),
        .m_occupancy     (m_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic answer_t table_apply(request_t rq);
        answer_t a;
        int hit;
        int hits;
        int i;
        a = '{default: '0};
        hit = -1;
        hits = 0;
        case (rq.op)
            OP_INSERT: begin
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && !slot_used[i]) hit = i;
                if (hit < 0) begin
                    a.st = ST_FULL;
                    n_full++;
                end else begin
                    slot_val[hit] = rq.value;
                    slot_used[hit] = 1'b1;
                    fill++;
                    a.idx = IDX_W'(hit);
                end
            end
            OP_REMOVE: begin
                if (int'(rq.receipt) < SLOTS && slot_used[rq.receipt]) begin
                    slot_used[rq.receipt] = 1'b0;
                    fill--;
                    a.removed = slot_val[rq.receipt];
                end else begin
                    a.st = ST_EMPTY;
                    n_miss++;
                end
            end
            OP_ERASE_ALL: begin
                for (i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_val[i] == rq.value) begin
                        slot_used[i] = 1'b0;
                        hits++;
                    end
                fill -= hits;
                a.cnt = CNT_W'(hits);
            end
            OP_ERASE_ONE: begin
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_used[i] && slot_val[i] == rq.value) hit = i;
                if (hit < 0) begin
                    a.st = ST_EMPTY;
                    n_miss++;
                end else begin
                    slot_used[hit] = 1'b0;
                    fill--;
                    a.idx = IDX_W'(hit);
                end
            end
            OP_COUNT: begin
                for (i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_val[i] == rq.value) hits++;
                a.cnt = CNT_W'(hits);
            end
            default: ;
        endcase
        if (fill > peak_fill) peak_fill = fill;
        a.occ = CNT_W'(fill);
        return a;
    endfunction

    function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic queue_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                 logic [RC_W-1:0] receipt);
        request_t rq;
        rq.op = op;
        rq.value = value;
        rq.receipt = receipt;
        requests_pending.push_back(rq);
        n_queued++;
    endtask

    // next request is built from the settled table once the last one is taken
    task automatic await_turn();
        do begin
            @(posedge aclk);
            #1;
        end while (n_in != n_queued);
    endtask

    // lean 0 fills the table, 1 mixes, 2 drains it
    task automatic queue_random(int lean);
        int live [$];
        int ins_pct;
        int roll;
        int i;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [RC_W-1:0]  receipt;
        for (i = 0; i < SLOTS; i++)
            if (slot_used[i]) live.push_back(i);
        case (lean)
            0: ins_pct = 80;
            1: ins_pct = 35;
            default: ins_pct = 10;
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            op = OP_INSERT;
        end else begin
            roll = $urandom_range(99);
            if (roll < 35) op = OP_REMOVE;
            else if (roll < 55) op = OP_ERASE_ONE;
            else if (roll < 70) op = OP_ERASE_ALL;
            else if (roll < 92) op = OP_COUNT;
            else op = OP_W'($urandom_range(int'(OP_TOP), int'(OP_COUNT) + 1));
        end
        value = ($urandom_range(99) < 70) ? value_pool[$urandom_range(7)] : $urandom();
        receipt = RC_W'($urandom());
        if (live.size() != 0 && $urandom_range(99) < 75) begin
            if (op == OP_REMOVE)
                receipt = RC_W'(live[$urandom_range(live.size() - 1)]);
            else if (op == OP_ERASE_ALL || op == OP_ERASE_ONE || op == OP_COUNT)
                value = slot_val[live[$urandom_range(live.size() - 1)]];
        end
        queue_request(op, value, receipt);
    endtask

    // driver
    always @(negedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_beat) begin
            if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                rq = requests_pending.pop_front();
                s_operation <= rq.op;
                s_item_value <= rq.value;
                s_receipt <= rq.receipt;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side ready, with a single long hold
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        answer_t  due;
        request_t rq;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_out++;
                if (answers_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %0d",
                             $time, m_status);
                    errors++;
                end else begin
                    due = answers_due.pop_front();
                    check_field("slot_index", VAL_W'(due.idx), VAL_W'(m_slot_index));
                    check_field("removed_value", due.removed, m_removed_value);
                    check_field("match_count", VAL_W'(due.cnt), VAL_W'(m_match_count));
                    check_field("status", VAL_W'(due.st), VAL_W'(m_status));
                    check_field("occupancy", VAL_W'(due.occ), VAL_W'(m_occupancy));
                end
            end
            in_beat = s_valid && s_ready;
            if (in_beat) begin
                rq.op = s_operation;
                rq.value = s_item_value;
                rq.receipt = s_receipt;
                answers_due.push_back(table_apply(rq));
                n_in++;
            end
            if (in_beat || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_MAX) begin
                    $display("%0t: no beat for %0d cycles, %0d results outstanding",
                             $time, quiet, answers_due.size());
                    $display("tb_slot_table_with_receipts: done, errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        int phase;
        int k;
        for (k = 0; k < SLOTS; k++) begin
            slot_used[k] = 1'b0;
            slot_val[k] = '0;
        end
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (k = 4; k < 8; k++) value_pool[k] = $urandom();

        // empty table corners
        queue_request(OP_COUNT, 32'h0000_0000, 5'd0);
        queue_request(OP_REMOVE, 32'h0000_0000, 5'd0);
        queue_request(OP_ERASE_ONE, 32'h0000_0000, 5'd0);
        queue_request(OP_ERASE_ALL, 32'h0000_0000, 5'd0);
        // extremes and duplicates
        queue_request(OP_INSERT, 32'h8000_0000, 5'd31);
        queue_request(OP_INSERT, 32'h7fff_ffff, 5'd0);
        queue_request(OP_INSERT, 32'h0000_0000, 5'd0);
        queue_request(OP_INSERT, 32'hffff_ffff, 5'd0);
        queue_request(OP_INSERT, 32'h7fff_ffff, 5'd0);
        queue_request(OP_COUNT, 32'h7fff_ffff, 5'd0);
        queue_request(OP_ERASE_ONE, 32'h7fff_ffff, 5'd0);
        queue_request(OP_ERASE_ALL, 32'h7fff_ffff, 5'd0);
        queue_request(OP_ERASE_ALL, 32'hffff_ffff, 5'd0);
        queue_request(OP_REMOVE, 32'h0000_0000, 5'd0);
        queue_request(OP_REMOVE, 32'h0000_0000, 5'd0);
        queue_request(OP_REMOVE, 32'h0000_0000, 5'd31);
        // stale value in a freed slot must not match
        queue_request(OP_ERASE_ONE, 32'h8000_0000, 5'd0);
        queue_request(OP_COUNT, 32'h8000_0000, 5'd0);
        // unused operation codes
        queue_request(OP_COUNT + 3'd1, 32'h5555_5555, 5'h15);
        queue_request(OP_COUNT + 3'd2, 32'haaaa_aaaa, 5'h0a);
        queue_request(OP_TOP, 32'hffff_ffff, 5'h1f);
        queue_request(OP_COUNT, 32'h0000_0000, 5'd0);
        queue_request(OP_INSERT, 32'h1234_5678, 5'd0);
        queue_request(OP_REMOVE, 32'h0000_0000, 5'd2);

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin send_idle_pct = 63; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 63; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                await_turn();
                if (phase == 0 && k == 120) hold_asks++;
                queue_random((k / 50) % 3);
            end
        end

        while (n_in != n_queued || answers_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("ran %0d requests and %0d results through five idle/stall mixes", n_in, n_out);
        $display("table full %0d times, empty slot or no match %0d times, peak occupancy %0d",
                 n_full, n_miss, peak_fill);
        if (errors == 0) begin
            $display("tb_slot_table_with_receipts: done, clean");
        end else begin
            $display("tb_slot_table_with_receipts: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/stwr_pkg.sv
hdl/stwr_cell.sv
hdl/slot_table_with_receipts.sv
tb/sv/tb_slot_table_with_receipts.sv
